### rtl/length_header_field_splitter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length header field splitter
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LENGTH_HEADER_FIELD_SPLITTER_TOP_ASSERT_SVH
`define LENGTH_HEADER_FIELD_SPLITTER_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define LHFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define LHFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lhfs_pkg.sv
// ----------------------------------------------------------------------------
// Length header field splitter package
// Shared widths, transaction payload types and the header event struct.
// ----------------------------------------------------------------------------
package lhfs_pkg;

  // Width of one decoded header length (saturating)
  localparam int LEN_BITS   = 16;
  localparam int NUM_FIELDS = 4;
  localparam int FIELD_BITS = $clog2(NUM_FIELDS);

  typedef logic [LEN_BITS-1:0] len_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_first;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0]            out_byte;
    logic [FIELD_BITS-1:0] field_index;
    logic                  field_last;
    logic                  message_done;
    logic                  header_error;
  } out_t;

  // Header parser to sequencer: one length closed by a comma
  typedef struct packed {
    logic comma;
    logic neg;
    len_t len;
  } hdr_evt_t;

endpackage

### rtl/lhfs_hdr_parse.sv
// ----------------------------------------------------------------------------
// Header length parser
// Decodes one decimal length per comma, atoi style, with saturation.
// ----------------------------------------------------------------------------
module lhfs_hdr_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              first,
  input  logic [7:0]        msg_byte,
  output lhfs_pkg::hdr_evt_t evt
);

  localparam int WIDE_BITS = lhfs_pkg::LEN_BITS + 4;
  localparam logic [WIDE_BITS-1:0] WIDE_MAX = {4'b0000, {lhfs_pkg::LEN_BITS{1'b1}}};

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  lhfs_pkg::len_t acc_r, acc_nxt, acc_cur;
  logic started_r, started_nxt, started_cur;
  logic stopped_r, stopped_nxt, stopped_cur;
  logic neg_r, neg_nxt, neg_cur;

  logic                 is_digit, is_space;
  logic [WIDE_BITS-1:0] wide_acc, prod;

  // Start of a new message sees a cleared number
  assign acc_cur     = first ? '0 : acc_r;
  assign started_cur = first ? 1'b0 : started_r;
  assign stopped_cur = first ? 1'b0 : stopped_r;
  assign neg_cur     = first ? 1'b0 : neg_r;

  // Classify the byte
  assign is_digit = (msg_byte >= CH_ZERO) && (msg_byte <= CH_NINE);
  assign is_space = (msg_byte == CH_SPACE) || ((msg_byte >= CH_TAB) && (msg_byte <= CH_CR));

  // Multiply by ten as two shifts, add the digit
  assign wide_acc = {4'b0000, acc_cur};
  assign prod     = (wide_acc << 3) + (wide_acc << 1) + {{(WIDE_BITS-4){1'b0}}, msg_byte[3:0]};

  // Report a finished length on a comma
  assign evt.comma = take && (msg_byte == CH_COMMA);
  assign evt.neg   = neg_cur;
  assign evt.len   = acc_cur;

  // Next number state
  always_comb begin
    acc_nxt     = acc_cur;
    started_nxt = started_cur;
    stopped_nxt = stopped_cur;
    neg_nxt     = neg_cur;
    if (msg_byte == CH_COMMA) begin
      acc_nxt     = '0;
      started_nxt = 1'b0;
      stopped_nxt = 1'b0;
      neg_nxt     = 1'b0;
    end else if (stopped_cur) begin
      // ignore trailing bytes up to the comma
    end else if (is_digit) begin
      acc_nxt     = (prod > WIDE_MAX) ? {lhfs_pkg::LEN_BITS{1'b1}}
                                      : prod[lhfs_pkg::LEN_BITS-1:0];
      started_nxt = 1'b1;
    end else if (!started_cur && is_space) begin
      // skip leading white space
    end else if (!started_cur && (msg_byte == CH_PLUS)) begin
      started_nxt = 1'b1;
    end else if (!started_cur && (msg_byte == CH_MINUS)) begin
      started_nxt = 1'b1;
      neg_nxt     = 1'b1;
    end else begin
      stopped_nxt = 1'b1;
    end
  end

  // Hold the number state, advance on each header byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      started_r <= 1'b0;
      stopped_r <= 1'b0;
      neg_r     <= 1'b0;
    end else if (take) begin
      acc_r     <= acc_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
      neg_r     <= neg_nxt;
    end
  end

endmodule

### rtl/length_header_field_splitter_top.sv
// ----------------------------------------------------------------------------
// Length header field splitter, top level
// Parses a four-length header and tags the payload bytes with field indexes.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle and gives at most one tagged
// payload byte per byte taken; header bytes and bytes past the last field give
// nothing. Each result is in the output register from the cycle after its byte
// is accepted, and in_ready is high whenever that register is empty or is being
// drained by out_ready, so with out_ready held high a byte enters every cycle.
// A byte with msg_first set clears all message state before it is parsed.
// ----------------------------------------------------------------------------
module length_header_field_splitter_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lhfs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lhfs_pkg::out_t out_data
);

  localparam int NF = lhfs_pkg::NUM_FIELDS;
  localparam int FB = lhfs_pkg::FIELD_BITS;

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DONE} phase_t;
  typedef logic [NF-1:0][lhfs_pkg::LEN_BITS-1:0] len_arr_t;
  typedef struct packed {
    logic          found;
    logic [FB-1:0] idx;
  } sel_t;

  // First non-empty field at or after start
  function automatic sel_t pick_field(input logic [FB:0] start, input len_arr_t lens,
                                      input logic [NF-1:0] unb);
    sel_t s;
    s = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if ((FB+1)'(i) >= start && (unb[i] || lens[i] != '0)) begin
        s.found = 1'b1;
        s.idx   = FB'(i);
      end
    end
    return s;
  endfunction

  phase_t          phase_r, phase_nxt, phase_cur;
  logic [FB-1:0]   comma_r, comma_nxt, comma_cur;
  len_arr_t        len_r, len_nxt, len_sel;
  logic [NF-1:0]   unb_r, unb_nxt, unb_sel;
  logic [FB-1:0]   cur_r, cur_nxt;
  lhfs_pkg::len_t  rem_r, rem_nxt, rem_dec;
  logic            err_r, err_nxt, err_cur;
  logic            out_valid_r;
  lhfs_pkg::out_t  out_data_r, res;
  logic            emit;

  logic               in_acc, hdr_take;
  lhfs_pkg::hdr_evt_t evt;
  sel_t               sel;

  // Accept while the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // A first byte sees a fresh message
  assign phase_cur = in_data.msg_first ? PH_HEADER : phase_r;
  assign comma_cur = in_data.msg_first ? '0 : comma_r;
  assign err_cur   = in_data.msg_first ? 1'b0 : err_r;
  assign hdr_take  = in_acc && (phase_cur == PH_HEADER);

  lhfs_hdr_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (hdr_take),
    .first    (in_data.msg_first),
    .msg_byte (in_data.msg_byte),
    .evt      (evt)
  );

  // Step the message sequencer and build the result
  always_comb begin
    phase_nxt = phase_cur;
    comma_nxt = comma_cur;
    len_nxt   = len_r;
    unb_nxt   = unb_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    err_nxt   = err_cur;
    emit      = 1'b0;
    len_sel   = len_r;
    unb_sel   = unb_r;
    sel       = '0;
    rem_dec   = rem_r - {{(lhfs_pkg::LEN_BITS-1){1'b0}}, (rem_r != '0)};
    res              = '0;
    res.out_byte     = in_data.msg_byte;
    res.field_index  = cur_r;
    res.header_error = err_r;
    unique case (phase_cur)
      PH_HEADER: begin
        if (evt.comma) begin
          len_nxt[comma_cur] = evt.len;
          unb_nxt[comma_cur] = evt.neg;
          err_nxt            = err_cur | evt.neg;
          if (comma_cur == FB'(NF - 1)) begin
            len_sel   = len_nxt;
            unb_sel   = unb_nxt;
            sel       = pick_field('0, len_sel, unb_sel);
            comma_nxt = '0;
            cur_nxt   = sel.idx;
            rem_nxt   = len_sel[sel.idx];
            phase_nxt = sel.found ? PH_PAYLOAD : PH_DONE;
          end else begin
            comma_nxt = comma_cur + 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        if (!unb_r[cur_r]) begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            res.field_last = 1'b1;
            sel = pick_field({1'b0, cur_r} + 1'b1, len_r, unb_r);
            if (sel.found) begin
              cur_nxt = sel.idx;
              rem_nxt = len_r[sel.idx];
            end else begin
              res.message_done = 1'b1;
              phase_nxt        = PH_DONE;
            end
          end
        end
      end
      PH_DONE: begin
        // drop bytes past the last field
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      comma_r     <= '0;
      cur_r       <= '0;
      rem_r       <= '0;
      err_r       <= 1'b0;
      len_r       <= '0;
      unb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        comma_r <= comma_nxt;
        cur_r   <= cur_nxt;
        rem_r   <= rem_nxt;
        err_r   <= err_nxt;
        len_r   <= len_nxt;
        unb_r   <= unb_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_acc && emit;
        out_data_r  <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/lhfs_checker.sv
// ----------------------------------------------------------------------------
// Length header field splitter port checker
// Watches the top level ports and flags sequencing and handshake slips.
// ----------------------------------------------------------------------------
`include "length_header_field_splitter_top_assert.svh"

module lhfs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input lhfs_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input lhfs_pkg::out_t out_data
);

  // Stalled result transaction holds
  `LHFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "stalled result changed")

  // End of message closes its field
  `LHFS_ASSERT_SAME(a_done_last, out_valid && out_data.message_done,
                    out_data.field_last, "message_done without field_last")

  // Empty output register never blocks input
  `LHFS_ASSERT_SAME(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

  // First byte of a message is header, so it gives no result
  `LHFS_ASSERT_NEXT(a_first_silent, in_valid && in_ready && in_data.msg_first,
                    !out_valid, "result from first byte")

endmodule

bind length_header_field_splitter_top lhfs_checker u_lhfs_checker (.*);
